[design/regex_pattern_tokenizer_assert.svh]
// Assertion macros for the regex pattern tokenizer.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef REGEX_PATTERN_TOKENIZER_ASSERT_SVH
`define REGEX_PATTERN_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpt check failed");

// Next-cycle implication, disabled in reset.
`define RPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpt check failed");

`endif

[design/rpt_pkg.sv]
// Types and constants shared by the regex pattern tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package rpt_pkg;

  localparam int unsigned CLASS_SET_BITS = 128;
  localparam int unsigned CHAR_BITS      = 7;

  typedef logic [CLASS_SET_BITS-1:0] class_set_t;
  typedef logic [CHAR_BITS-1:0]      char_t;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       end_of_pattern;
  } pat_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [6:0]  token_char;
    logic [63:0] class_low_bits;
    logic [63:0] class_high_bits;
  } tok_item_t;

  // Token kinds
  localparam logic [3:0] KIND_CHAR     = 4'd0;
  localparam logic [3:0] KIND_PERIOD   = 4'd1;
  localparam logic [3:0] KIND_LPAREN   = 4'd2;
  localparam logic [3:0] KIND_RPAREN   = 4'd3;
  localparam logic [3:0] KIND_CLASS    = 4'd4;
  localparam logic [3:0] KIND_STAR     = 4'd5;
  localparam logic [3:0] KIND_PLUS     = 4'd6;
  localparam logic [3:0] KIND_QUESTION = 4'd7;
  localparam logic [3:0] KIND_CONCAT   = 4'd8;
  localparam logic [3:0] KIND_OR       = 4'd9;

  // Pattern characters
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_PERIOD    = 8'h2E;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_D         = 8'h64;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_FIRST_VIS = 8'h21;
  localparam logic [7:0] CH_LAST_VIS  = 8'h7E;
  localparam char_t      CH_MAX       = 7'd127;

endpackage

[design/regex_pattern_tokenizer.sv]
// Regex pattern tokenizer, one pattern byte per cycle while tok_stall does not hold the token register.
// The byte register feeds a single pass of lexer logic (mode decode, one
// range mask, class set update) into the token register, and the lexer state
// loop closes on the same step that feeds the token register. A byte is held
// in the input register and its token is then registered on tok; a byte that
// completes no token produces nothing on tok. Classes leave as one token
// with a 128-bit membership set. After a byte flagged end_of_pattern the
// lexer returns to idle with an empty class.
// Depends on rpt_pkg, rpt_lexer, rpt_range_mask and the assertion header.
`timescale 1ns / 1ps

module regex_pattern_tokenizer (
  input  logic               clk,
  input  logic               rst,
  // pattern request channel
  input  logic               pat_valid,
  output logic               pat_stall,
  input  rpt_pkg::pat_item_t pat,
  // token request channel
  output logic               tok_valid,
  input  logic               tok_stall,
  output rpt_pkg::tok_item_t tok
);
  import rpt_pkg::*;
  `include "regex_pattern_tokenizer_assert.svh"

  // input register
  logic      held_valid;
  pat_item_t held;

  // lexer output before the token register
  logic      lex_hit;
  tok_item_t lex_tok;

  logic      out_free;
  logic      advance;

  // token register frees up when empty or being taken this cycle
  assign out_free  = !tok_valid || !tok_stall;
  // held byte goes through the lexer when the token register can take it
  assign advance   = held_valid && out_free;
  // a new request lands when the input register is empty or emptying
  assign pat_stall = held_valid && !advance;

  rpt_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .pat     (held),
    .tok_hit (lex_hit),
    .tok     (lex_tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!pat_stall) begin
      held_valid <= pat_valid;
    end
    if (!pat_stall && pat_valid) begin
      held <= pat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (out_free) begin
      tok_valid <= advance && lex_hit;
    end
    if (advance && lex_hit) begin
      tok <= lex_tok;
    end
  end

  // stall is only raised while a byte is held
  `RPT_ASSERT_NOW(a_stall_held, clk, rst, pat_stall, held_valid)
  // a held byte that cannot move is still there next cycle
  `RPT_ASSERT_NEXT(a_held_kept, clk, rst, held_valid && !advance, held_valid)
  // only class tokens carry membership bits
  `RPT_ASSERT_NOW(a_bits_class, clk, rst, tok_valid && tok.token_kind != KIND_CLASS,
    tok.class_low_bits == '0 && tok.class_high_bits == '0)
  // class tokens always carry the open bracket
  `RPT_ASSERT_NOW(a_class_char, clk, rst, tok_valid && tok.token_kind == KIND_CLASS,
    tok.token_char == CH_LBRACKET[6:0])

endmodule

[design/rpt_range_mask.sv]
// Membership mask for an inclusive character range, empty when reversed.
// Depends on rpt_pkg.
`timescale 1ns / 1ps

module rpt_range_mask (
  input  logic          en,
  input  rpt_pkg::char_t lo,
  input  rpt_pkg::char_t hi,
  output rpt_pkg::class_set_t mask
);
  import rpt_pkg::*;

  class_set_t from_lo;
  class_set_t to_hi;

  always_comb begin
    from_lo = {CLASS_SET_BITS{1'b1}} << lo;
    to_hi   = {CLASS_SET_BITS{1'b1}} >> (CH_MAX - hi);
    // a reversed range leaves the two halves disjoint, so the AND is empty
    mask    = en ? (from_lo & to_hi) : '0;
  end

endmodule

[design/rpt_lexer.sv]
// Lexer state and next-state logic: one pattern byte per step.
// Depends on rpt_pkg and rpt_range_mask.
`timescale 1ns / 1ps

module rpt_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  rpt_pkg::pat_item_t pat,
  output logic               tok_hit,
  output rpt_pkg::tok_item_t tok
);
  import rpt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_FIRST   = 3'd2,
    MODE_BODY    = 3'd3,
    MODE_PENDING = 3'd4,
    MODE_DASH    = 3'd5
  } mode_t;

  mode_t      mode, mode_next;
  char_t      pending, pending_next;
  class_set_t class_set, class_set_next;

  logic       clear;
  logic       add_en;
  logic       add_dash;
  char_t      add_lo, add_hi;
  class_set_t add_mask;
  logic       with_set;
  char_t      sat;
  logic [7:0] b;

  rpt_range_mask u_range (
    .en   (add_en),
    .lo   (add_lo),
    .hi   (add_hi),
    .mask (add_mask)
  );

  always_comb begin
    b            = pat.pattern_byte;
    sat          = b[7] ? CH_MAX : b[6:0];
    mode_next    = mode;
    pending_next = pending;
    clear        = 1'b0;
    add_en       = 1'b0;
    add_dash     = 1'b0;
    add_lo       = pending;
    add_hi       = pending;
    with_set     = 1'b0;
    tok_hit      = 1'b0;
    tok.token_kind = KIND_CHAR;
    tok.token_char = b[6:0];

    case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_IDLE;
        if (b == CH_D) begin
          clear    = 1'b1;
          add_en   = 1'b1;
          add_lo   = CH_ZERO[6:0];
          add_hi   = CH_NINE[6:0];
          with_set = 1'b1;
        end else if (!b[7]) begin
          tok_hit = 1'b1;
        end
      end
      MODE_FIRST: begin
        if (b == CH_RBRACKET) begin
          mode_next = MODE_IDLE;
          with_set  = 1'b1;
        end else if (b == CH_DASH) begin
          add_en    = 1'b1;
          add_lo    = CH_DASH[6:0];
          add_hi    = CH_DASH[6:0];
          mode_next = MODE_BODY;
        end else begin
          pending_next = sat;
          mode_next    = MODE_PENDING;
        end
      end
      MODE_BODY: begin
        if (b == CH_RBRACKET) begin
          mode_next = MODE_IDLE;
          with_set  = 1'b1;
        end else begin
          pending_next = sat;
          mode_next    = MODE_PENDING;
        end
      end
      MODE_PENDING: begin
        if (b == CH_RBRACKET) begin
          add_en    = 1'b1;
          mode_next = MODE_IDLE;
          with_set  = 1'b1;
        end else if (b == CH_DASH && pending != CH_LBRACKET[6:0]) begin
          mode_next = MODE_DASH;
        end else begin
          add_en       = 1'b1;
          pending_next = sat;
        end
      end
      MODE_DASH: begin
        add_en = 1'b1;
        if (b == CH_RBRACKET) begin
          add_dash  = 1'b1;
          mode_next = MODE_IDLE;
          with_set  = 1'b1;
        end else begin
          add_hi    = sat;
          mode_next = MODE_BODY;
        end
      end
      default: begin
        // idle, and the two unused codes behave as idle
        mode_next = MODE_IDLE;
        case (b)
          CH_BACKSLASH: mode_next = MODE_ESCAPE;
          CH_PERIOD:   begin tok_hit = 1'b1; tok.token_kind = KIND_PERIOD;   end
          CH_AT:       begin tok_hit = 1'b1; tok.token_kind = KIND_CONCAT;   end
          CH_BAR:      begin tok_hit = 1'b1; tok.token_kind = KIND_OR;       end
          CH_PLUS:     begin tok_hit = 1'b1; tok.token_kind = KIND_PLUS;     end
          CH_STAR:     begin tok_hit = 1'b1; tok.token_kind = KIND_STAR;     end
          CH_QUESTION: begin tok_hit = 1'b1; tok.token_kind = KIND_QUESTION; end
          CH_LPAREN:   begin tok_hit = 1'b1; tok.token_kind = KIND_LPAREN;   end
          CH_RPAREN:   begin tok_hit = 1'b1; tok.token_kind = KIND_RPAREN;   end
          CH_LBRACKET: begin
            clear     = 1'b1;
            mode_next = MODE_FIRST;
          end
          default: tok_hit = b inside {[CH_FIRST_VIS:CH_LAST_VIS]};
        endcase
      end
    endcase

    class_set_next = (clear ? '0 : class_set) | add_mask
                   | (add_dash ? (class_set_t'(1) << CH_DASH[6:0]) : '0);

    if (with_set) begin
      tok_hit        = 1'b1;
      tok.token_kind = KIND_CLASS;
      tok.token_char = CH_LBRACKET[6:0];
    end
    tok.class_low_bits  = with_set ? class_set_next[63:0]   : '0;
    tok.class_high_bits = with_set ? class_set_next[127:64] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pending   <= '0;
      class_set <= '0;
    end else if (step) begin
      if (pat.end_of_pattern) begin
        mode      <= MODE_IDLE;
        pending   <= '0;
        class_set <= '0;
      end else begin
        mode      <= mode_next;
        pending   <= pending_next;
        class_set <= class_set_next;
      end
    end
  end

endmodule
